// File: hw/rtl/tla_pkg.sv
package tla_pkg;

  localparam int CAP_W       = 4;
  localparam int STREAK_W    = 8;
  localparam int MAX_WAITING = 255;
  localparam int WAIT_W      = $clog2(MAX_WAITING + 1);
  localparam int RESULT_CAP  = 15;
  localparam int NUM_W       = $clog2(RESULT_CAP);
  localparam int CFG_DATA_W  = 8;
  localparam int ERR_W       = 2;

  localparam logic [CAP_W-1:0]    CAP_RESET   = CAP_W'(3);
  localparam logic [STREAK_W-1:0] LIMIT_RESET = STREAK_W'(5);
  localparam logic [STREAK_W-1:0] STREAK_MAX  = {STREAK_W{1'b1}};
  localparam logic [WAIT_W-1:0]   WAIT_MAX    = WAIT_W'(MAX_WAITING);

  localparam logic [1:0] DIR_NEUTRAL = 2'd0;
  localparam logic [1:0] DIR_NORTH   = 2'd1;
  localparam logic [1:0] DIR_SOUTH   = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_DEPART   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

  localparam logic KIND_ARRIVAL   = 1'b0;
  localparam logic KIND_DEPARTURE = 1'b1;
  localparam logic SIDE_NORTH     = 1'b0;
  localparam logic SIDE_SOUTH     = 1'b1;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_LIMIT    = 1'b1;

  typedef struct packed {
    logic load_event;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic final_result;
  } status_t;

endpackage

// File: hw/rtl/tla_dp.sv
module tla_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  tla_pkg::cmd_t                      cmd,
  output tla_pkg::status_t                   status,
  input  logic                               kind,
  input  logic                               side,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [tla_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               granted,
  output logic                               grant_side,
  output logic [tla_pkg::CAP_W-1:0]          occupants,
  output logic [tla_pkg::STREAK_W-1:0]       streak_now,
  output logic [tla_pkg::ERR_W-1:0]          error,
  output logic                               last
);

  logic [tla_pkg::CAP_W-1:0]    capacity;
  logic [tla_pkg::STREAK_W-1:0] streak_limit;
  logic [tla_pkg::CAP_W-1:0]    occ;
  logic [1:0]                   dir;
  logic [tla_pkg::STREAK_W-1:0] streak;
  logic [tla_pkg::WAIT_W-1:0]   wait_north;
  logic [tla_pkg::WAIT_W-1:0]   wait_south;
  logic                         pref;
  logic [tla_pkg::ERR_W-1:0]    err;
  logic [tla_pkg::NUM_W-1:0]    num;

  // event application
  logic [tla_pkg::ERR_W-1:0]    ev_err;
  logic [tla_pkg::WAIT_W-1:0]   ev_north;
  logic [tla_pkg::WAIT_W-1:0]   ev_south;
  logic [tla_pkg::CAP_W-1:0]    ev_occ;
  logic [1:0]                   ev_dir;
  logic [tla_pkg::STREAK_W-1:0] ev_streak;
  logic                         ev_pref;
  logic [tla_pkg::WAIT_W-1:0]   ev_w_side;
  logic [tla_pkg::WAIT_W-1:0]   ev_w_other;

  always_comb begin
    ev_err     = tla_pkg::ERR_NONE;
    ev_north   = wait_north;
    ev_south   = wait_south;
    ev_occ     = occ;
    ev_dir     = dir;
    ev_streak  = streak;
    ev_pref    = side;
    ev_w_side  = (side == tla_pkg::SIDE_SOUTH) ? wait_south : wait_north;
    ev_w_other = (side == tla_pkg::SIDE_SOUTH) ? wait_north : wait_south;
    if (kind == tla_pkg::KIND_ARRIVAL) begin
      if (ev_w_side >= tla_pkg::WAIT_MAX) begin
        ev_err = tla_pkg::ERR_OVERFLOW;
      end else if (side == tla_pkg::SIDE_SOUTH) begin
        ev_south = wait_south + tla_pkg::WAIT_W'(1);
      end else begin
        ev_north = wait_north + tla_pkg::WAIT_W'(1);
      end
    end else begin
      if (occ == '0 || dir != {1'b0, side} + 2'd1) begin
        ev_err = tla_pkg::ERR_DEPART;
      end else begin
        ev_occ = occ - tla_pkg::CAP_W'(1);
        if (ev_occ == '0) begin
          // resource empties: hand over to the other side if it waits
          ev_dir    = tla_pkg::DIR_NEUTRAL;
          ev_streak = '0;
          ev_pref   = (ev_w_other != '0) ? ~side : side;
        end
      end
    end
  end

  // admission decision
  logic                         sel;
  logic                         neutral;
  logic                         dir_ok;
  logic [tla_pkg::WAIT_W-1:0]   w_sel;
  logic [tla_pkg::WAIT_W-1:0]   w_opp;
  logic                         room;
  logic                         admit_ok;
  logic                         more_ok;
  logic [tla_pkg::STREAK_W-1:0] streak_inc;
  logic [tla_pkg::CAP_W-1:0]    occ_inc;

  always_comb begin
    neutral = (dir == tla_pkg::DIR_NEUTRAL);
    dir_ok  = 1'b1;
    if (neutral) begin
      sel = ((pref ? wait_south : wait_north) != '0) ? pref : ~pref;
    end else begin
      sel    = (dir == tla_pkg::DIR_SOUTH);
      dir_ok = (dir == tla_pkg::DIR_NORTH) || (dir == tla_pkg::DIR_SOUTH);
    end
    w_sel      = sel ? wait_south : wait_north;
    w_opp      = sel ? wait_north : wait_south;
    room       = occ < capacity;
    admit_ok   = room && (w_sel != '0) && dir_ok &&
                 (neutral || !(streak >= streak_limit && w_opp != '0));
    streak_inc = (streak == tla_pkg::STREAK_MAX) ? streak
                                                 : streak + tla_pkg::STREAK_W'(1);
    occ_inc    = occ + tla_pkg::CAP_W'(1);
    // look ahead at the state after this admission
    more_ok    = (w_sel > tla_pkg::WAIT_W'(1)) && (occ_inc < capacity) &&
                 !(streak_inc >= streak_limit && w_opp != '0) &&
                 (num != tla_pkg::NUM_W'(tla_pkg::RESULT_CAP - 1));
    status.final_result = !admit_ok || !more_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= tla_pkg::CAP_RESET;
      streak_limit <= tla_pkg::LIMIT_RESET;
      occ          <= '0;
      dir          <= tla_pkg::DIR_NEUTRAL;
      streak       <= '0;
      wait_north   <= '0;
      wait_south   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tla_pkg::CFG_CAPACITY: capacity     <= cfg_data[tla_pkg::CAP_W-1:0];
          tla_pkg::CFG_LIMIT:    streak_limit <= cfg_data[tla_pkg::STREAK_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load_event) begin
        occ        <= ev_occ;
        dir        <= ev_dir;
        streak     <= ev_streak;
        wait_north <= ev_north;
        wait_south <= ev_south;
      end else if (cmd.emit && admit_ok) begin
        occ    <= occ_inc;
        dir    <= sel ? tla_pkg::DIR_SOUTH : tla_pkg::DIR_NORTH;
        streak <= streak_inc;
        if (sel) begin
          wait_south <= wait_south - tla_pkg::WAIT_W'(1);
        end else begin
          wait_north <= wait_north - tla_pkg::WAIT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_event) begin
      pref <= ev_pref;
      err  <= ev_err;
      num  <= '0;
    end else if (cmd.emit) begin
      num <= num + tla_pkg::NUM_W'(1);
    end
    if (cmd.emit) begin
      error <= err;
      last  <= status.final_result;
      if (admit_ok) begin
        granted    <= 1'b1;
        grant_side <= sel;
        occupants  <= occ_inc;
        streak_now <= streak_inc;
      end else begin
        granted    <= 1'b0;
        grant_side <= tla_pkg::SIDE_NORTH;
        occupants  <= occ;
        streak_now <= streak;
      end
    end
  end

`ifndef SYNTHESIS
  a_empty_neutral: assert property (@(posedge clk) disable iff (rst)
    (occ == '0) == (dir == tla_pkg::DIR_NEUTRAL))
    else $error("occupant count and direction disagree");

  a_neutral_streak: assert property (@(posedge clk) disable iff (rst)
    (dir == tla_pkg::DIR_NEUTRAL) |-> (streak == '0))
    else $error("streak kept while neutral");

  a_admit_fills: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && admit_ok) |=> (occ == $past(occ) + tla_pkg::CAP_W'(1)))
    else $error("admission did not raise occupant count");
`endif

endmodule

// File: hw/rtl/tla_ctrl.sv
module tla_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tla_pkg::cmd_t     cmd,
  input  tla_pkg::status_t  status
);

  typedef enum logic {
    S_IDLE,
    S_ADMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.load_event = 1'b0;
    cmd.emit       = 1'b0;
    unique case (state)
      S_IDLE:  cmd.load_event = in_valid;
      S_ADMIT: cmd.emit       = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_ADMIT;
        end
        S_ADMIT: begin
          // stay until the final result of this transaction is loaded
          if (cmd.emit && status.final_result) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADMIT && out_valid && !out_ready) |=> (state == S_ADMIT))
    else $error("left admission while output stalled");
`endif

endmodule

// File: hw/rtl/two_way_lane_arbiter.sv
// Two-way lane arbiter for a one-lane resource shared by a north and a south side.
// Input channel (in_valid/in_ready, kind, side): one arrival or departure per
// transaction. Output channel (out_valid/out_ready): one result per admitted
// user, or a single result with granted low when nobody is admitted; last
// marks the final result of each input. Config channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) writes capacity (index 0) and streak_limit (index 1);
// it is always ready; it must be written only while the block is idle, a rule
// for the user that the block itself does not enforce. The event is applied at
// the accepting edge and the first result is loaded into the output register
// once the output is free, then one result per cycle while the receiver does
// not stall; an input admits at most 15 users and the next input is taken
// only after its final result. Admission uses one compare-and-update datapath.
// Reset: capacity 3, streak limit 5, no occupants, neutral direction, no
// waiters, output empty.
// When the receiver stalls, the pending result holds in the output register
// and admission pauses; no result is lost or repeated.
module two_way_lane_arbiter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic                              side,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              granted,
  output logic                              grant_side,
  output logic [tla_pkg::CAP_W-1:0]         occupants,
  output logic [tla_pkg::STREAK_W-1:0]      streak_now,
  output logic [tla_pkg::ERR_W-1:0]         error,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [tla_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tla_pkg::cmd_t    cmd;
  tla_pkg::status_t status;

  assign cfg_ready = 1'b1;

  tla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  tla_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .kind       (kind),
    .side       (side),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .granted    (granted),
    .grant_side (grant_side),
    .occupants  (occupants),
    .streak_now (streak_now),
    .error      (error),
    .last       (last)
  );

endmodule
